>>> sv/deq_pkg.sv
// shared types and codes for the double-ended queue
// request codes, status codes, default depth and the per-beat result info
// no dependencies
`default_nettype none

package deq_pkg;

  // default number of ring entries
  localparam int unsigned DEPTH_DEFAULT = 16;

  // payload widths fixed by the interface
  localparam int unsigned DATA_W = 32;
  localparam int unsigned REQ_W  = 3;
  localparam int unsigned STAT_W = 2;

  // request codes
  localparam logic [REQ_W-1:0] REQ_ADD_FRONT  = 3'd0;
  localparam logic [REQ_W-1:0] REQ_ADD_BACK   = 3'd1;
  localparam logic [REQ_W-1:0] REQ_REM_FRONT  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_REM_BACK   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_PEEK_FRONT = 3'd4;
  localparam logic [REQ_W-1:0] REQ_PEEK_BACK  = 3'd5;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  // result info for one beat, carried alongside the memory read
  typedef struct packed {
    logic              rd_ok;
    logic [STAT_W-1:0] status;
    logic              is_empty;
    logic              is_full;
  } deq_info_t;

endpackage

`default_nettype wire

>>> sv/deq_mem.sv
// entry storage for the double-ended queue
// one write port and one read port, read data registered
// uses deq_pkg for the data width
`default_nettype none

module deq_mem #(
  parameter int unsigned DEPTH = deq_pkg::DEPTH_DEFAULT,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                       clk_i,
  input  logic                       wr_en_i,
  input  logic [AW-1:0]              wr_addr_i,
  input  logic [deq_pkg::DATA_W-1:0] wr_data_i,
  input  logic                       rd_en_i,
  input  logic [AW-1:0]              rd_addr_i,
  output logic [deq_pkg::DATA_W-1:0] rd_data_o
);
  import deq_pkg::*;

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

>>> sv/deq_ctrl.sv
// head, tail and count bookkeeping for the double-ended queue
// decodes a request, drives the memory ports and produces the result info
// uses deq_pkg for request and status codes
`default_nettype none

module deq_ctrl #(
  parameter int unsigned DEPTH = deq_pkg::DEPTH_DEFAULT,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  parameter int unsigned CW    = $clog2(DEPTH + 1)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      accept_i,
  input  logic [deq_pkg::REQ_W-1:0] req_type_i,
  output logic                      wr_en_o,
  output logic [AW-1:0]             wr_addr_o,
  output logic                      rd_en_o,
  output logic [AW-1:0]             rd_addr_o,
  output deq_pkg::deq_info_t        info_o
);
  import deq_pkg::*;

  localparam logic [AW-1:0] LastPtr = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FullCnt = CW'(DEPTH);

  logic [AW-1:0] head_q, head_d;
  logic [AW-1:0] tail_q, tail_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [AW-1:0] head_inc, head_dec, tail_inc, tail_dec;
  logic          is_empty_now, is_full_now;
  logic          wr_en, rd_en;
  logic          rd_ok;
  logic [STAT_W-1:0] status;

  // ring neighbors of both pointers
  assign head_inc = (head_q == LastPtr) ? '0 : head_q + 1'b1;
  assign head_dec = (head_q == '0) ? LastPtr : head_q - 1'b1;
  assign tail_inc = (tail_q == LastPtr) ? '0 : tail_q + 1'b1;
  assign tail_dec = (tail_q == '0) ? LastPtr : tail_q - 1'b1;

  assign is_empty_now = (cnt_q == '0);
  assign is_full_now  = (cnt_q == FullCnt);

  // request decode
  always_comb begin
    head_d    = head_q;
    tail_d    = tail_q;
    cnt_d     = cnt_q;
    wr_en     = 1'b0;
    wr_addr_o = tail_q;
    rd_en     = 1'b0;
    rd_addr_o = head_q;
    rd_ok     = 1'b0;
    status    = ST_OK;
    unique case (req_type_i)
      REQ_ADD_FRONT: begin
        if (is_full_now) begin
          status = ST_FULL;
        end else begin
          head_d    = head_dec;
          wr_en     = 1'b1;
          wr_addr_o = head_dec;
          cnt_d     = cnt_q + 1'b1;
        end
      end
      REQ_ADD_BACK: begin
        if (is_full_now) begin
          status = ST_FULL;
        end else begin
          tail_d    = tail_inc;
          wr_en     = 1'b1;
          wr_addr_o = tail_q;
          cnt_d     = cnt_q + 1'b1;
        end
      end
      REQ_REM_FRONT: begin
        if (is_empty_now) begin
          status = ST_EMPTY;
        end else begin
          rd_en     = 1'b1;
          rd_ok     = 1'b1;
          rd_addr_o = head_q;
          head_d    = head_inc;
          cnt_d     = cnt_q - 1'b1;
        end
      end
      REQ_REM_BACK: begin
        if (is_empty_now) begin
          status = ST_EMPTY;
        end else begin
          rd_en     = 1'b1;
          rd_ok     = 1'b1;
          rd_addr_o = tail_dec;
          tail_d    = tail_dec;
          cnt_d     = cnt_q - 1'b1;
        end
      end
      REQ_PEEK_FRONT: begin
        if (is_empty_now) begin
          status = ST_EMPTY;
        end else begin
          rd_en     = 1'b1;
          rd_ok     = 1'b1;
          rd_addr_o = head_q;
        end
      end
      REQ_PEEK_BACK: begin
        if (is_empty_now) begin
          status = ST_EMPTY;
        end else begin
          rd_en     = 1'b1;
          rd_ok     = 1'b1;
          rd_addr_o = tail_dec;
        end
      end
      default: begin
        // unused codes leave everything as it is
        status = ST_OK;
      end
    endcase
  end

  // memory strobes only on an accepted beat
  assign wr_en_o = accept_i & wr_en;
  assign rd_en_o = accept_i & rd_en;

  // result info, flags as they stand after the request
  assign info_o.rd_ok    = rd_ok;
  assign info_o.status   = status;
  assign info_o.is_empty = (cnt_d == '0);
  assign info_o.is_full  = (cnt_d == FullCnt);

  // pointer and count registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      cnt_q  <= '0;
    end else if (accept_i) begin
      head_q <= head_d;
      tail_q <= tail_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

`default_nettype wire

>>> sv/double_ended_queue.sv
// double-ended queue of signed 32-bit values on a ring buffer in one memory
// a result goes through the read stage and the output register
// throughput: one request per cycle while in_stall_o is low; the memory
// has a single read port and the pointers move on each accepted beat
// reset clears head, tail, count and the pipeline valids; memory is not reset
// uses deq_pkg, deq_ctrl and deq_mem
`default_nettype none

module double_ended_queue #(
  parameter int unsigned DEPTH = deq_pkg::DEPTH_DEFAULT
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [deq_pkg::REQ_W-1:0]         req_type_i,
  input  logic signed [deq_pkg::DATA_W-1:0] data_in_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [deq_pkg::DATA_W-1:0] data_out_o,
  output logic [deq_pkg::STAT_W-1:0]        status_o,
  output logic                              is_empty_o,
  output logic                              is_full_o
);
  import deq_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic              accept;
  logic              advance;
  logic              wr_en, rd_en;
  logic [AW-1:0]     wr_addr, rd_addr;
  logic [DATA_W-1:0] rd_data;
  deq_info_t         info;

  // read stage: waits for the memory data
  logic      s1_valid_q;
  deq_info_t s1_info_q;

  // output register
  logic              out_valid_q;
  logic [DATA_W-1:0] out_data_q;
  deq_info_t         out_info_q;

  // handshake
  assign advance    = s1_valid_q & (~out_valid_q | ~out_stall_i);
  assign in_stall_o = s1_valid_q & ~advance;
  assign accept     = in_valid_i & ~in_stall_o;

  deq_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .req_type_i (req_type_i),
    .wr_en_o    (wr_en),
    .wr_addr_o  (wr_addr),
    .rd_en_o    (rd_en),
    .rd_addr_o  (rd_addr),
    .info_o     (info)
  );

  deq_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (DATA_W'(data_in_i)),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // read stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  // read stage info
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_info_q <= info;
    end
  end

  // output beat valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (~out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output beat payload, zero data unless a value was read
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_info_q <= s1_info_q;
      out_data_q <= s1_info_q.rd_ok ? rd_data : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign data_out_o  = $signed(out_data_q);
  assign status_o    = out_info_q.status;
  assign is_empty_o  = out_info_q.is_empty;
  assign is_full_o   = out_info_q.is_full;

endmodule

`default_nettype wire

>>> test/tb_top.sv
// self-checking testbench for double_ended_queue: random and directed request beats,
// expected replies kept by an in-bench deque predictor, replies compared field by field
// depends on deq_pkg and double_ended_queue
module tb_top;
  import deq_pkg::*;

  localparam int unsigned RING_DEPTH = DEPTH_DEFAULT;
  localparam int unsigned PTR_W = $clog2(RING_DEPTH);
  localparam int unsigned CNT_W = $clog2(RING_DEPTH + 1);
  localparam int ITEM_TARGET = 640;
  localparam int HOLD_CYCLES = 60;
  localparam int CYCLE_LIMIT = 200000;

  // request codes the block leaves unused
  localparam logic [REQ_W-1:0] REQ_SPARE_6 = 3'd6;
  localparam logic [REQ_W-1:0] REQ_SPARE_7 = 3'd7;

  typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_e;
  typedef enum logic [1:0] {BIAS_FILL, BIAS_DRAIN, BIAS_MIXED} bias_e;

  // one expected reply beat
  typedef struct {
    logic signed [DATA_W-1:0] data;
    logic [STAT_W-1:0]        status;
    logic                     empty;
    logic                     full;
  } deq_reply_t;

  // deque predictor and store of replies still due
  class deque_scoreboard;
    logic signed [DATA_W-1:0] ring [RING_DEPTH];
    logic [PTR_W-1:0]         head;
    logic [PTR_W-1:0]         tail;
    logic [CNT_W-1:0]         fill;
    deq_reply_t               replies_due[$];
    int                       errors;

    function new();
      head = '0;
      tail = '0;
      fill = '0;
      errors = 0;
    endfunction

    function logic [PTR_W-1:0] ptr_up(logic [PTR_W-1:0] p);
      return (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function logic [PTR_W-1:0] ptr_down(logic [PTR_W-1:0] p);
      return (p == '0) ? PTR_W'(RING_DEPTH - 1) : p - 1'b1;
    endfunction

    function int pending();
      return replies_due.size();
    endfunction

    // update the ring for one accepted request and queue its reply
    function void note_request(logic [REQ_W-1:0] kind, logic signed [DATA_W-1:0] value);
      deq_reply_t r;
      r.data = '0;
      r.status = ST_OK;
      case (kind)
        REQ_ADD_FRONT, REQ_ADD_BACK: begin
          if (fill == RING_DEPTH) begin
            r.status = ST_FULL;
          end else if (kind == REQ_ADD_FRONT) begin
            head = ptr_down(head);
            ring[head] = value;
            fill++;
          end else begin
            ring[tail] = value;
            tail = ptr_up(tail);
            fill++;
          end
        end
        REQ_REM_FRONT, REQ_REM_BACK, REQ_PEEK_FRONT, REQ_PEEK_BACK: begin
          if (fill == 0) begin
            r.status = ST_EMPTY;
          end else begin
            case (kind)
              REQ_REM_FRONT: begin
                r.data = ring[head];
                head = ptr_up(head);
                fill--;
              end
              REQ_REM_BACK: begin
                tail = ptr_down(tail);
                r.data = ring[tail];
                fill--;
              end
              REQ_PEEK_FRONT: r.data = ring[head];
              default:        r.data = ring[ptr_down(tail)];
            endcase
          end
        end
        default: ;
      endcase
      r.empty = (fill == 0);
      r.full = (fill == RING_DEPTH);
      replies_due.push_back(r);
    endfunction

    task report_mismatch(string field, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
      if (errors < 40) $display("mismatch on %s: got %0h, expected %0h", field, got, want);
      errors++;
    endtask

    // compare one reply beat with the oldest expectation
    task check_reply(logic signed [DATA_W-1:0] data, logic [STAT_W-1:0] status,
                     logic empty, logic full);
      deq_reply_t r;
      if (replies_due.size() == 0) begin
        report_mismatch("unexpected reply beat", data, '0);
      end else begin
        r = replies_due.pop_front();
        if (data !== r.data) report_mismatch("data_out", data, r.data);
        if (status !== r.status) report_mismatch("status", status, r.status);
        if (empty !== r.empty) report_mismatch("is_empty", empty, r.empty);
        if (full !== r.full) report_mismatch("is_full", full, r.full);
      end
    endtask
  endclass

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid_i = 1'b0;
  logic                     in_stall_o;
  logic [REQ_W-1:0]         req_type_i = '0;
  logic signed [DATA_W-1:0] data_in_i = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic signed [DATA_W-1:0] data_out_o;
  logic [STAT_W-1:0]        status_o;
  logic                     is_empty_o;
  logic                     is_full_o;

  deque_scoreboard sb = new();
  int cycle_count = 0;
  int real_items = 0;
  int hold_seq = 0;

  double_ended_queue #(.DEPTH(RING_DEPTH)) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .req_type_i  (req_type_i),
    .data_in_i   (data_in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .data_out_o  (data_out_o),
    .status_o    (status_o),
    .is_empty_o  (is_empty_o),
    .is_full_o   (is_full_o)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // reply side: check accepted beats, drive the stall pattern
  int          hold_left = 0;
  int          hold_seen = 0;
  int          seg_left = 0;
  stall_mode_e stall_mode = STALL_NONE;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_reply(data_out_o, status_o, is_empty_o, is_full_o);
    end
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_seen != hold_seq) begin
      // long hold-off so the block backs up into its input
      hold_seen <= hold_seq;
      hold_left <= HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else begin
      if (seg_left == 0) begin
        seg_left <= $urandom_range(10, 80);
        stall_mode <= stall_mode_e'($urandom_range(0, 3));
      end else begin
        seg_left <= seg_left - 1;
      end
      case (stall_mode)
        STALL_NONE:  out_stall_i <= 1'b0;
        STALL_LIGHT: out_stall_i <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall_i <= ($urandom_range(0, 9) < 7);
        default:     out_stall_i <= (cycle_count % 4 == 3);
      endcase
    end
  end

  // offer one request beat and wait until it is taken
  task send_request(logic [REQ_W-1:0] kind, logic signed [DATA_W-1:0] value);
    in_valid_i <= 1'b1;
    req_type_i <= kind;
    data_in_i <= value;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_request(kind, value);
    if (kind <= REQ_PEEK_BACK) real_items++;
  endtask

  task idle_for(int n);
    if (n > 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // hold the input until every reply is back
  task wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  function logic signed [DATA_W-1:0] random_value();
    case ($urandom_range(0, 19))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return '0;
      3:       return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  // request mix leaning toward filling, draining or neither
  function logic [REQ_W-1:0] pick_kind(bias_e bias);
    int roll;
    int add_pct;
    roll = $urandom_range(0, 99);
    add_pct = (bias == BIAS_FILL) ? 62 : (bias == BIAS_DRAIN) ? 25 : 46;
    if (roll < add_pct) return ($urandom_range(0, 1) == 0) ? REQ_ADD_FRONT : REQ_ADD_BACK;
    if (roll < 96) begin
      case ($urandom_range(0, 3))
        0:       return REQ_REM_FRONT;
        1:       return REQ_REM_BACK;
        2:       return REQ_PEEK_FRONT;
        default: return REQ_PEEK_BACK;
      endcase
    end
    return ($urandom_range(0, 1) == 0) ? REQ_SPARE_6 : REQ_SPARE_7;
  endfunction

  logic signed [DATA_W-1:0] extreme_vals [4];
  bias_e bias;
  int    phase_no;
  int    burst_left;

  initial begin
    extreme_vals[0] = 32'sh7fff_ffff;
    extreme_vals[1] = 32'sh8000_0000;
    extreme_vals[2] = -32'sd1;
    extreme_vals[3] = '0;
    phase_no = 0;
    burst_left = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reads on an empty deque and the unused codes
    send_request(REQ_PEEK_FRONT, 32'sh5a5a_a5a5);
    send_request(REQ_PEEK_BACK, random_value());
    send_request(REQ_REM_FRONT, random_value());
    send_request(REQ_REM_BACK, random_value());
    send_request(REQ_SPARE_6, random_value());
    send_request(REQ_SPARE_7, random_value());
    // fill from both ends with extreme values first, wrapping the head
    for (int i = 0; i < RING_DEPTH; i++) begin
      send_request(i[0] ? REQ_ADD_BACK : REQ_ADD_FRONT,
                   (i < 4) ? extreme_vals[i] : random_value());
    end
    // add on a full deque, then read both ends
    send_request(REQ_ADD_BACK, random_value());
    send_request(REQ_PEEK_FRONT, random_value());
    send_request(REQ_PEEK_BACK, random_value());
    send_request(REQ_REM_FRONT, random_value());
    send_request(REQ_REM_BACK, random_value());
    wait_drained();

    // random phases with bursts and gaps on the request side
    while (real_items < ITEM_TARGET) begin
      phase_no++;
      bias = bias_e'($urandom_range(0, 2));
      if (phase_no == 3 || phase_no == 11) begin
        hold_seq <= hold_seq + 1;
        repeat (30) send_request(pick_kind(bias), random_value());
      end
      repeat ($urandom_range(20, 60)) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          if ($urandom_range(0, 2) != 0) idle_for($urandom_range(1, 6));
        end
        send_request(pick_kind(bias), random_value());
        burst_left--;
      end
      if (phase_no % 5 == 0) wait_drained();
    end

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (sb.pending() != 0) sb.report_mismatch("replies never seen", sb.pending(), '0);
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
